// ----- sv/base64_lenient_stream_decoder_unit_defines.svh -----
// Assertion macros used by the base64 decoder output queue.
`ifndef BASE64_LENIENT_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_LENIENT_STREAM_DECODER_UNIT_DEFINES_SVH

// Clocked check, held off while reset is asserted
`define B64D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset
`define B64D_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/b64d_pkg.sv -----
// Shared types, character codes and decode functions for the base64 decoder.
package b64d_pkg;

  // Special characters
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharUnder = 8'h5F;

  // Result queue depth, in bundles
  localparam int unsigned BundleDepth = 2;
  localparam int unsigned BundlePtrW  = $clog2(BundleDepth);

  // Register index of url_safe
  localparam logic RegUrlSafe = 1'b0;

  // Decoded character: hit is low for a non-alphabet character
  typedef struct packed {
    logic       hit;
    logic [5:0] val;
  } sextet_t;

  // All results caused by one input item
  typedef struct packed {
    logic [1:0]      cnt;     // number of results, 1..3
    logic [2:0][7:0] bytes;   // bytes[0] leaves first
    logic            bvalid;  // low only for an empty end marker
    logic            last;    // set when the bundle ends the message
  } bundle_t;

  function automatic sextet_t sextet_of(logic [7:0] c, logic url_safe);
    sextet_t s;
    s.hit = 1'b1;
    s.val = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.val = 6'(c - 8'h47);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.val = 6'(c + 8'h04);
    end else if (c == CharPlus || (url_safe && c == CharDash)) begin
      s.val = 6'd62;
    end else if (c == CharSlash || (url_safe && c == CharUnder)) begin
      s.val = 6'd63;
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

  // Four sextets to three bytes
  function automatic logic [2:0][7:0] group_bytes(logic [5:0] s0, logic [5:0] s1,
                                                  logic [5:0] s2, logic [5:0] s3);
    logic [2:0][7:0] b;
    b[0] = {s0, s1[5:4]};
    b[1] = {s1[3:0], s2[5:2]};
    b[2] = {s2[1:0], s3};
    return b;
  endfunction

endpackage

// ----- sv/b64d_decode.sv -----
// Input register, group state and combinational decode of one character.
module b64d_decode import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       url_safe_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       end_of_message_i,
  input  logic       q_full_i,
  output logic       push_o,
  output bundle_t    bundle_o
);

  logic            item_vld_q;
  logic [7:0]      char_q;
  logic            eom_q;
  logic [1:0]      gc_q, gc_d;
  logic            stopped_q, stopped_d;
  logic [5:0]      store_q [3];
  logic [5:0]      store_d [3];
  logic            advance;
  sextet_t         sx;
  logic [2:0][7:0] grp, flush;
  logic [1:0]      n;
  bundle_t         bundle;

  // Item leaves the input register once the result queue has room
  assign advance    = item_vld_q && !q_full_i;
  assign in_ready_o = !item_vld_q || !q_full_i;

  // Decode against the current group state
  always_comb begin
    sx        = sextet_of(char_q, url_safe_i);
    gc_d      = gc_q;
    stopped_d = stopped_q;
    store_d   = store_q;
    n         = 2'd0;
    bundle    = '0;
    bundle.bvalid = 1'b1;
    grp = group_bytes(store_q[0], store_q[1], store_q[2], sx.val);
    if (!stopped_q) begin
      if (char_q == CharEq) begin
        stopped_d = 1'b1;
      end else if (!sx.hit) begin
        // literal copy, partial group dropped
        gc_d = 2'd0;
        n    = 2'd1;
        bundle.bytes[0] = char_q;
      end else if (gc_q == 2'd3) begin
        gc_d = 2'd0;
        n    = 2'd3;
        bundle.bytes = grp;
      end else begin
        store_d[gc_q] = sx.val;
        gc_d = gc_q + 2'd1;
      end
    end
    flush = group_bytes(store_d[0], store_d[1], (gc_d == 2'd3) ? store_d[2] : 6'd0, 6'd0);
    // Message end: flush partial group, else an empty marker
    if (eom_q) begin
      if (gc_d >= 2'd2) begin
        n = gc_d - 2'd1;
        bundle.bytes = flush;
      end
      if (n == 2'd0) begin
        n = 2'd1;
        bundle.bytes  = '0;
        bundle.bvalid = 1'b0;
      end
      bundle.last = 1'b1;
      gc_d      = 2'd0;
      stopped_d = 1'b0;
    end
    bundle.cnt = n;
  end

  assign push_o   = advance && (n != 2'd0);
  assign bundle_o = bundle;

  // Input register and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      gc_q       <= 2'd0;
      stopped_q  <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        item_vld_q <= 1'b1;
      end else if (advance) begin
        item_vld_q <= 1'b0;
      end
      if (advance) begin
        gc_q      <= gc_d;
        stopped_q <= stopped_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_in_i;
      eom_q  <= end_of_message_i;
    end
    if (advance) begin
      store_q <= store_d;
    end
  end

endmodule

// ----- sv/b64d_out_queue.sv -----
// Result bundle queue and output serializer, one byte per cycle while out_ready_i is high.
`include "base64_lenient_stream_decoder_unit_defines.svh"

module b64d_out_queue import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bundle_t    bundle_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] byte_out_o,
  output logic       byte_valid_o,
  output logic       last_o
);

  localparam int unsigned CntW = $clog2(BundleDepth + 1);

  bundle_t                mem_q [BundleDepth];
  logic [BundlePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]        count_q;
  logic [1:0]             idx_q;
  bundle_t                head;
  logic                   at_end, pop;

  assign head   = mem_q[rd_ptr_q];
  assign full_o = (count_q == CntW'(BundleDepth));
  assign at_end = (idx_q == head.cnt - 2'd1);

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i && at_end;

  // Pick the current byte of the head bundle
  always_comb begin
    case (idx_q)
      2'd0:    byte_out_o = head.bytes[0];
      2'd1:    byte_out_o = head.bytes[1];
      2'd2:    byte_out_o = head.bytes[2];
      default: byte_out_o = '0;
    endcase
  end
  assign byte_valid_o = head.bvalid;
  assign last_o       = head.last && at_end;

  // Pointers, fill count and byte index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      idx_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
        idx_q    <= 2'd0;
      end else if (out_valid_o && out_ready_i) begin
        idx_q <= idx_q + 2'd1;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Bundle storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= bundle_i;
    end
  end

  `B64D_ASSERT(a_no_overflow, !(push_i && full_o), "bundle pushed into a full queue")
  `B64D_ASSERT_ALWAYS(a_count_range, !rst_ni || count_q <= CntW'(BundleDepth), "queue count out of range")
  `B64D_ASSERT(a_idx_in_bundle, out_valid_o |-> (idx_q < head.cnt),
               "byte index beyond bundle size")
  `B64D_ASSERT(a_marker_shape, (push_i && !bundle_i.bvalid) |->
               (bundle_i.cnt == 2'd1 && bundle_i.last), "malformed end marker")
  `B64D_ASSERT(a_drain, (pop && !push_i && count_q == CntW'(1)) |=> !out_valid_o,
               "queue not empty after last bundle left")

endmodule

// ----- sv/base64_lenient_stream_decoder_unit.sv -----
// Top level of the lenient streaming base64 decoder with url-safe option.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in      | sink      | in_valid_i/in_ready_o  | char_in_i, end_of_message_i
//  out     | source    | out_valid_o/out_ready_i| byte_out_o, byte_valid_o, last_o
//  cfg     | APB slave | psel/penable/pready    | paddr, pwdata, prdata
//
// An input transfer is registered, decoded combinationally and its 0..3 result
// bytes land in a two-bundle queue; in_ready_o drops only while the input
// register holds an item and the queue is full.
// One result transfer leaves per cycle while out_ready_i is high; an item
// waits in the input register, its results then in the queue.
// Reset clears group count, stop flag, queue and url_safe; no clearing pass.
// A stall on the output backs up the queue, then the input register.
module base64_lenient_stream_decoder_unit import b64d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  input  logic        end_of_message_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  byte_out_o,
  output logic        byte_valid_o,
  output logic        last_o
);

  logic    url_safe_q;
  logic    q_full, push;
  bundle_t bundle;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegUrlSafe) ? {31'd0, url_safe_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_safe_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegUrlSafe) begin
      url_safe_q <= pwdata[0];
    end
  end

  b64d_decode u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .url_safe_i       (url_safe_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_in_i        (char_in_i),
    .end_of_message_i (end_of_message_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .bundle_o         (bundle)
  );

  b64d_out_queue u_out_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .bundle_i     (bundle),
    .full_o       (q_full),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .byte_out_o   (byte_out_o),
    .byte_valid_o (byte_valid_o),
    .last_o       (last_o)
  );

endmodule

// ----- dv/b64_decode_checker.sv -----
// Checker for the base64 decoder: predicts decoded bytes from observed transfers and compares.
module b64_decode_checker import b64d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port, watched for url_safe writes
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  // input channel
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  input  logic        end_of_message_i,
  // output channel
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [7:0]  byte_out_o,
  input  logic        byte_valid_o,
  input  logic        last_o,
  // status for the testbench top
  output int          mismatch_cnt_o,
  output int          pending_o,
  output int          checked_o
);

  localparam logic [2:0] UrlSafeAddr = 3'(4 * RegUrlSafe);

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       last;
  } dec_result_t;

  // Expected output transfers, oldest first
  dec_result_t expected_bytes[$];

  // Shadow decoder state
  logic       url_safe_q = 1'b0;
  logic [1:0] group_cnt  = 2'd0;
  logic [5:0] held_sextets [3];
  logic       halted     = 1'b0;

  int mismatches = 0;
  int checked    = 0;

  // Character to 6-bit value; hit low for anything outside the alphabet
  function automatic sextet_t classify(logic [7:0] c, logic url);
    sextet_t s;
    s.hit = 1'b1;
    s.val = '0;
    if (c >= "A" && c <= "Z") begin
      s.val = 6'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      s.val = 6'(c - "a" + 8'd26);
    end else if (c >= "0" && c <= "9") begin
      s.val = 6'(c - "0" + 8'd52);
    end else if (c == CharPlus || (url && c == CharDash)) begin
      s.val = 6'd62;
    end else if (c == CharSlash || (url && c == CharUnder)) begin
      s.val = 6'd63;
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

  // Decode one accepted character and queue the bytes it releases
  task automatic predict_decode(input logic [7:0] c, input logic eom);
    sextet_t     s;
    logic [23:0] word;
    dec_result_t res [3];
    int          n;
    n = 0;
    if (!halted) begin
      if (c == CharEq) begin
        halted = 1'b1;
      end else begin
        s = classify(c, url_safe_q);
        if (!s.hit) begin
          // literal copy, partial group dropped
          group_cnt = 2'd0;
          res[n] = '{data: c, data_valid: 1'b1, last: 1'b0};
          n++;
        end else if (group_cnt == 2'd3) begin
          word = {held_sextets[0], held_sextets[1], held_sextets[2], s.val};
          for (int k = 0; k < 3; k++) begin
            res[n] = '{data: word[23 - 8 * k -: 8], data_valid: 1'b1, last: 1'b0};
            n++;
          end
          group_cnt = 2'd0;
        end else begin
          held_sextets[group_cnt] = s.val;
          group_cnt = group_cnt + 2'd1;
        end
      end
    end
    // End of message: flush partial group, then clear the group count and stop flag
    if (eom) begin
      if (group_cnt >= 2'd2) begin
        word = {held_sextets[0], held_sextets[1],
                (group_cnt == 2'd3) ? held_sextets[2] : 6'd0, 6'd0};
        for (int k = 0; k < int'(group_cnt) - 1; k++) begin
          res[n] = '{data: word[23 - 8 * k -: 8], data_valid: 1'b1, last: 1'b0};
          n++;
        end
      end
      if (n == 0) begin
        res[n] = '{data: 8'h00, data_valid: 1'b0, last: 1'b1};
        n++;
      end else begin
        res[n - 1].last = 1'b1;
      end
      group_cnt = 2'd0;
      halted    = 1'b0;
    end
    for (int k = 0; k < n; k++) expected_bytes.push_back(res[k]);
  endtask

  // Compare one output transfer with the oldest expectation
  task automatic check_result();
    dec_result_t want;
    if (expected_bytes.size() == 0) begin
      $error("unexpected result: byte_out %02h byte_valid %0b last %0b",
             byte_out_o, byte_valid_o, last_o);
      mismatches++;
    end else begin
      want = expected_bytes.pop_front();
      checked++;
      if (byte_out_o !== want.data) begin
        $error("byte_out: expected %02h, actual %02h", want.data, byte_out_o);
        mismatches++;
      end
      if (byte_valid_o !== want.data_valid) begin
        $error("byte_valid: expected %0b, actual %0b", want.data_valid, byte_valid_o);
        mismatches++;
      end
      if (last_o !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, last_o);
        mismatches++;
      end
    end
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      url_safe_q = 1'b0;
      group_cnt  = 2'd0;
      halted     = 1'b0;
      expected_bytes.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == UrlSafeAddr) begin
        url_safe_q = pwdata[0];
      end
      if (in_valid_i && in_ready_o) predict_decode(char_in_i, end_of_message_i);
      if (out_valid_o && out_ready_i) check_result();
    end
    pending_o      <= expected_bytes.size();
    mismatch_cnt_o <= mismatches;
    checked_o      <= checked;
  end

endmodule

// ----- dv/tb_base64_lenient_stream_decoder_unit.sv -----
// Testbench top for the base64 decoder: stimulus, idling, watchdog and verdict.
module tb_base64_lenient_stream_decoder_unit;
  import b64d_pkg::*;

  localparam logic [2:0] UrlSafeAddr = 3'(4 * RegUrlSafe);
  localparam int DrainCycles = 4;     // covers the latency, plus margin
  localparam int HoldCycles  = 64;    // long output stall
  localparam int QuietLimit  = 3000;  // cycles without any transfer

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_in_i = '0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  byte_out_o;
  logic        byte_valid_o;
  logic        last_o;

  int mismatch_cnt;
  int pending;
  int checked;

  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         hold_req = 1'b0;
  bit         url_mode = 1'b0;
  logic [7:0] msg_chars[$];
  int         items_sent = 0;
  int         messages_sent = 0;
  int         quiet = 0;

  base64_lenient_stream_decoder_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_in_i        (char_in_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .byte_out_o       (byte_out_o),
    .byte_valid_o     (byte_valid_o),
    .last_o           (last_o)
  );

  b64_decode_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_in_i        (char_in_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .byte_out_o       (byte_out_o),
    .byte_valid_o     (byte_valid_o),
    .last_o           (last_o),
    .mismatch_cnt_o   (mismatch_cnt),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Receiver: random backpressure, or a long stall on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run if no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pwrite && pready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("base64_lenient_stream_decoder_unit: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Setup and access cycle on the config port
  task automatic apb_write(input logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= UrlSafeAddr;
    pwdata  <= {31'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop sending and wait until every expected byte has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Push msg_chars through the input channel, end flag on the last one
  task automatic send_message();
    int gap;
    foreach (msg_chars[i]) begin
      gap = 0;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i       <= 1'b1;
      char_in_i        <= msg_chars[i];
      end_of_message_i <= (i == msg_chars.size() - 1);
      do @(posedge clk_i); while (!in_ready_o);
      items_sent++;
    end
    messages_sent++;
  endtask

  task automatic send_text(input string s);
    msg_chars.delete();
    for (int i = 0; i < s.len(); i++) msg_chars.push_back(s[i]);
    send_message();
  endtask

  // Random alphabet character; url-safe forms half the time when enabled, else one in eight
  function automatic logic [7:0] alpha_char();
    int v;
    bit alt;
    v   = $urandom_range(63);
    alt = url_mode ? $urandom_range(1) : ($urandom_range(7) == 0);
    if (v < 26) return 8'(8'h41 + v);
    if (v < 52) return 8'(8'h61 + v - 26);
    if (v < 62) return 8'(8'h30 + v - 52);
    if (v == 62) return alt ? CharDash : CharPlus;
    return alt ? CharUnder : CharSlash;
  endfunction

  // Mostly well-formed messages with random content, the rest noise
  task automatic build_message();
    int groups;
    int tail;
    int len;
    int r;
    msg_chars.delete();
    if ($urandom_range(99) < 70) begin
      groups = $urandom_range(4);
      tail   = $urandom_range(2);
      tail   = (tail == 0) ? 0 : tail + 1;
      repeat (groups * 4 + tail) msg_chars.push_back(alpha_char());
      if (tail != 0 && $urandom_range(1)) repeat (4 - tail) msg_chars.push_back(CharEq);
      if (msg_chars.size() == 0) msg_chars.push_back(alpha_char());
    end else begin
      len = $urandom_range(1, 10);
      repeat (len) begin
        r = $urandom_range(99);
        if (r < 55) msg_chars.push_back(alpha_char());
        else if (r < 70) msg_chars.push_back(CharEq);
        else if (r < 80) msg_chars.push_back($urandom_range(1) ? CharDash : CharUnder);
        else msg_chars.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  // One random phase at a given idle mix and url_safe setting
  task automatic run_phase(input int s_pct, input int r_pct, input bit url, input int quota);
    int start;
    settle();
    apb_write(url);
    url_mode      = url;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = items_sent;
    while (items_sent - start < quota) begin
      build_message();
      send_message();
    end
  endtask

  // Main sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_write(1'b0);
    url_mode = 1'b0;

    // Directed: full group, partial groups, pad stop, literals, byte extremes
    send_text("TWFu");
    send_text("TQ");
    send_text("TWE");
    send_text("T");
    send_text("QQ=!=");
    send_text("AB#z/+9");
    msg_chars = '{8'h00, CharDash, CharUnder, 8'hFF};
    send_message();

    // Random phases: receiver-heavy idling, sender-heavy idling, none
    run_phase(35, 80, 1'b1, 160);
    run_phase(80, 35, 1'b0, 160);
    run_phase(0, 0, 1'b1, 90);

    // Long output stall while the sender keeps offering, then full drain
    hold_req = 1'b1;
    msg_chars.delete();
    repeat (24) msg_chars.push_back(alpha_char());
    send_message();
    settle();

    run_phase(0, 0, 1'b0, 90);
    settle();

    $display("covered %0d characters in %0d messages, %0d results checked",
             items_sent, messages_sent, checked);
    $display("url_safe off and on, three idle mixes, one long output stall");
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("base64_lenient_stream_decoder_unit: match");
    end else begin
      $display("base64_lenient_stream_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/b64d_pkg.sv
sv/b64d_decode.sv
sv/b64d_out_queue.sv
sv/base64_lenient_stream_decoder_unit.sv
dv/b64_decode_checker.sv
dv/tb_base64_lenient_stream_decoder_unit.sv
